@@ hw/rtl/bmp_palette_pixel_expander_unit_defines.svh @@
// Assertion macros shared by the palette pixel expander RTL.
`ifndef BMP_PALETTE_PIXEL_EXPANDER_UNIT_DEFINES_SVH
`define BMP_PALETTE_PIXEL_EXPANDER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BMPPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another one on the next edge.
`define BMPPE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/bmppe_pkg.sv @@
// Shared types and constants of the palette pixel expander.
package bmppe_pkg;

  localparam int unsigned DEF_MAX_WIDTH     = 4096;
  localparam int unsigned DEF_PALETTE_DEPTH = 256;
  localparam int unsigned HEIGHT_LIMIT      = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned POS_W      = 12;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP_CODE   = 3'd0,
    CFG_WIDTH      = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_TOP_DOWN   = 3'd3,
    CFG_PAL_COLORS = 3'd4
  } cfg_idx_e;

  // Pixel index width codes
  typedef enum logic [1:0] {
    BPP_1 = 2'd0,
    BPP_2 = 2'd1,
    BPP_4 = 2'd2,
    BPP_8 = 2'd3
  } bpp_code_e;

  // Input request kinds
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

endpackage

@@ hw/rtl/bmp_palette_pixel_expander_unit.sv @@
// Top level of the palette pixel expander: row counters, pixel sequencer, output stage.
// Expands palette-indexed BMP row bytes into RGB888 pixels. Palette writes (tuser=0) store
// one entry each. A data byte (tuser=1) yields one pixel per cycle while the sink does not
// stall, up to 8, 4, 2 or 1 pixels at 1, 2, 4 or 8 bits per pixel; padding bytes and bytes
// past the row width or the image end give nothing. The pixel rate is set by the single read
// port of the palette RAM, which serves one pixel lookup a cycle. The
// next byte is accepted in the cycle the current byte issues its final lookup, and a
// registered output stage holds a finished pixel while the sink stalls. The palette RAM
// needs no clearing after reset; entries must be written before pixels refer to them.
`include "bmp_palette_pixel_expander_unit_defines.svh"

module bmp_palette_pixel_expander_unit
  import bmppe_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int unsigned PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,  // palette_index, entry_color, data_byte
  input  logic                  s_axis_tuser,  // op
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,  // column, image_row, pixel_color
  output logic                  m_axis_tlast,  // last
  output logic                  m_axis_tuser   // image_end
);

  localparam int unsigned WMAX     = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int unsigned CW       = $clog2(WMAX + 1);
  localparam int unsigned PADB_MAX = ((WMAX + 3) / 4) * 4;
  localparam int unsigned BW       = $clog2(PADB_MAX);
  localparam int unsigned AW       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // ---------------------------------------------------------------- configuration
  logic [1:0]       bpp_code_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic             top_down_q;
  logic [8:0]       pal_colors_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_code_q   <= BPP_8;
      width_q      <= DIM_W'(1);
      height_q     <= DIM_W'(1);
      top_down_q   <= 1'b0;
      pal_colors_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BPP_CODE:   bpp_code_q   <= cfg_wdata_i[1:0];
        CFG_WIDTH:      width_q      <= cfg_wdata_i;
        CFG_HEIGHT:     height_q     <= cfg_wdata_i;
        CFG_TOP_DOWN:   top_down_q   <= cfg_wdata_i[0];
        CFG_PAL_COLORS: pal_colors_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- effective sizes
  logic [DIM_W-1:0] weff, heff;
  logic [15:0]      row_bits;
  logic [13:0]      row_bytes, padded_bytes;
  logic [8:0]       pal_full, psize;
  logic [3:0]       per_byte;

  // Clamp dimensions and derive padded row length and palette size
  always_comb begin
    if (width_q == '0) begin
      weff = DIM_W'(1);
    end else if (width_q > DIM_W'(WMAX)) begin
      weff = DIM_W'(WMAX);
    end else begin
      weff = width_q;
    end
    if (height_q == '0) begin
      heff = DIM_W'(1);
    end else if (height_q > DIM_W'(HEIGHT_LIMIT)) begin
      heff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      heff = height_q;
    end
    row_bits     = 16'(weff) << bpp_code_q;
    row_bytes    = 14'((row_bits + 16'd7) >> 3);
    padded_bytes = (row_bytes + 14'd3) & ~14'd3;
    case (bpp_code_q)
      BPP_1:   pal_full = 9'd2;
      BPP_2:   pal_full = 9'd4;
      BPP_4:   pal_full = 9'd16;
      default: pal_full = 9'd256;
    endcase
    psize    = (pal_colors_q == '0 || pal_colors_q > pal_full) ? pal_full : pal_colors_q;
    per_byte = 4'd8 >> bpp_code_q;
  end

  // ---------------------------------------------------------------- row counters
  logic [BW-1:0]    byte_in_row_q;
  logic [CW-1:0]    pixel_col_q;
  logic [DIM_W-1:0] rows_done_q;

  logic             in_acc, wr_en, data_acc, active, load;
  logic [DIM_W-1:0] pc_ext, remaining;
  logic [3:0]       npix;
  logic             last_row, row_end;
  logic [DIM_W-1:0] row_calc;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign wr_en    = in_acc && (s_axis_tuser == OP_PALETTE)
                    && ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_DEPTH));
  assign active   = rows_done_q < heff;
  assign data_acc = in_acc && (s_axis_tuser == OP_DATA) && active;

  // Count the pixels this byte yields and locate its row
  always_comb begin
    pc_ext    = DIM_W'(pixel_col_q);
    remaining = (pc_ext < weff) ? (weff - pc_ext) : '0;
    npix      = (remaining < DIM_W'(per_byte)) ? 4'(remaining) : per_byte;
    last_row  = rows_done_q == (heff - DIM_W'(1));
    row_calc  = top_down_q ? rows_done_q : (heff - DIM_W'(1) - rows_done_q);
    row_end   = (14'(byte_in_row_q) + 14'd1) >= padded_bytes;
  end

  assign load = data_acc && (npix != '0);

  // Advance byte, column and row counters per data byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_row_q <= '0;
      pixel_col_q   <= '0;
      rows_done_q   <= '0;
    end else if (data_acc) begin
      if (row_end) begin
        byte_in_row_q <= '0;
        pixel_col_q   <= '0;
        rows_done_q   <= rows_done_q + DIM_W'(1);
      end else begin
        byte_in_row_q <= byte_in_row_q + BW'(1);
        pixel_col_q   <= pixel_col_q + CW'(npix);
      end
    end
  end

  // ---------------------------------------------------------------- pixel sequencer
  logic             job_valid_q;
  logic [7:0]       job_sh_q;
  logic [1:0]       job_code_q;
  logic [2:0]       job_k_q;
  logic [3:0]       job_cnt_q;
  logic [CW-1:0]    job_col_q;
  logic [POS_W-1:0] job_row_q;
  logic [8:0]       job_psize_q;
  logic             job_end_q;

  logic             out_ready, advance, last_issue, idx_ok;
  logic [7:0]       idx, sh_next;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign advance       = job_valid_q && out_ready;
  assign last_issue    = advance && ({1'b0, job_k_q} == (job_cnt_q - 4'd1));
  assign s_axis_tready = !job_valid_q || last_issue;

  // Pick the leading pixel field and shift it out
  always_comb begin
    case (job_code_q)
      BPP_1: begin
        idx     = {7'd0, job_sh_q[7]};
        sh_next = job_sh_q << 1;
      end
      BPP_2: begin
        idx     = {6'd0, job_sh_q[7:6]};
        sh_next = job_sh_q << 2;
      end
      BPP_4: begin
        idx     = {4'd0, job_sh_q[7:4]};
        sh_next = job_sh_q << 4;
      end
      default: begin
        idx     = job_sh_q;
        sh_next = job_sh_q;
      end
    endcase
    idx_ok = ({1'b0, idx} < job_psize_q) && ({1'b0, idx} < 9'(PALETTE_DEPTH));
  end

  // Hold the current byte and step through its pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (load) begin
      job_valid_q <= 1'b1;
    end else if (last_issue) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_sh_q    <= s_axis_tdata[39:32];
      job_code_q  <= bpp_code_q;
      job_k_q     <= '0;
      job_cnt_q   <= npix;
      job_col_q   <= pixel_col_q;
      job_row_q   <= POS_W'(row_calc);
      job_psize_q <= psize;
      job_end_q   <= last_row && ((pc_ext + DIM_W'(npix)) == weff);
    end else if (advance) begin
      job_sh_q  <= sh_next;
      job_k_q   <= job_k_q + 3'd1;
      job_col_q <= job_col_q + CW'(1);
    end
  end

  // ---------------------------------------------------------------- palette memory
  logic [COLOR_W-1:0] rd_color;

  bmppe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(s_axis_tdata[7:0])),
    .wdata_i (s_axis_tdata[31:8]),
    .re_i    (advance && idx_ok),
    .raddr_i (AW'(idx)),
    .rdata_o (rd_color)
  );

  // ---------------------------------------------------------------- output stage
  logic             out_valid_q;
  logic [POS_W-1:0] out_col_q, out_row_q;
  logic             out_black_q, out_last_q, out_end_q;

  // Register one pixel; the RAM word stays put while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_col_q   <= POS_W'(job_col_q);
      out_row_q   <= job_row_q;
      out_black_q <= !idx_ok;
      out_last_q  <= last_issue;
      out_end_q   <= last_issue && job_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(out_black_q ? '0 : rd_color), out_row_q, out_col_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_end_q;

  // ---------------------------------------------------------------- assertions
  `BMPPE_ASSERT(a_end_is_last, (out_valid_q && out_end_q) |-> out_last_q, "image end not last")
  `BMPPE_ASSERT(a_k_in_range, job_valid_q |-> ({1'b0, job_k_q} < job_cnt_q), "pixel step overrun")
  `BMPPE_ASSERT_NEXT(a_job_drains, last_issue && !load, !job_valid_q, "byte still pending")
  `BMPPE_ASSERT(a_write_safe, wr_en |-> (!job_valid_q || last_issue), "palette write races read")

endmodule

@@ hw/rtl/bmppe_ram.sv @@
// Generic simple dual-port RAM with registered, read-first read port.
module bmppe_ram #(
  parameter  int unsigned WIDTH = 24,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
